/* hw/rtl/bmp_pkg.sv */
package bmp_pkg;

    // Queue between the parser and the pixel formatter.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIGIN_X       = 2'd0,
        REG_ORIGIN_Y       = 2'd1,
        REG_DISPLAY_WIDTH  = 2'd2,
        REG_DISPLAY_HEIGHT = 2'd3
    } reg_index_t;

    // File format constants.
    localparam logic [15:0] MAGIC_BM       = 16'h4D42;
    localparam logic [15:0] PLANES_ONE     = 16'd1;
    localparam logic [15:0] BITS_PER_PIXEL = 16'd24;
    localparam logic [7:0]  RED_MASK       = 8'hF8;
    localparam logic [7:0]  GREEN_MASK     = 8'hFC;
    localparam logic [31:0] HEADER_LEN     = 32'd34;

    // Byte positions at which a header field is complete.
    localparam logic [31:0] POS_MAGIC_END  = 32'd1;
    localparam logic [31:0] POS_OFFSET_END = 32'd13;
    localparam logic [31:0] POS_WIDTH_END  = 32'd21;
    localparam logic [31:0] POS_HEIGHT_END = 32'd25;
    localparam logic [31:0] POS_PLANES_END = 32'd27;
    localparam logic [31:0] POS_BPP_END    = 32'd29;
    localparam logic [31:0] POS_COMP_END   = 32'd33;

    typedef enum logic [2:0] {
        KIND_PIXEL      = 3'd0,
        KIND_OFFSCREEN  = 3'd1,
        KIND_BAD_MAGIC  = 3'd2,
        KIND_BAD_FORMAT = 3'd3,
        KIND_EMPTY      = 3'd4
    } kind_t;

    typedef enum logic [4:0] {
        PH_HEADER = 5'b00001,
        PH_SKIP   = 5'b00010,
        PH_PIXEL  = 5'b00100,
        PH_PAD    = 5'b01000,
        PH_DONE   = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       start_of_file;
    } file_item_t;

    typedef struct packed {
        kind_t              result_kind;
        logic [15:0]        pixel_rgb565;
        logic signed [15:0] screen_x;
        logic signed [15:0] screen_y;
        logic               last;
    } result_item_t;

    typedef struct packed {
        logic signed [15:0] origin_x;
        logic signed [15:0] origin_y;
        logic [15:0]        display_width;
        logic [15:0]        display_height;
    } cfg_regs_t;

    // One classified item handed from the parser to the formatter.
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [15:0] column;
        logic [15:0] row;
        logic [15:0] height;
        logic        last;
    } q_entry_t;

    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

/* hw/rtl/bmp24_stream_to_rgb565.sv */
// Channel   Direction  Handshake                  Payload
// file      in         file_valid / file_stall    file_item (file_byte, start_of_file)
// result    out        result_valid / result_stall result_item (kind, pixel, x, y, last)
// cfg       in         cfg_we                     cfg_index, cfg_data
//
// The block takes one file byte per clock while file_stall is low. The edge that
// accepts the byte completing a result writes it to a four-entry queue, from which
// the formatter moves it into the output register that drives result_valid.
// Reset clears the parser to the header state at byte 0, empties the queue and loads
// the configuration registers with origin 0,0 and a 240 by 240 display.
// While result_stall is high the queue absorbs up to four results; file_stall rises
// only when the queue is full, so bytes that produce no result keep flowing until then.
module bmp24_stream_to_rgb565 (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             file_valid,
    output logic                             file_stall,
    input  bmp_pkg::file_item_t              file_item,
    output logic                             result_valid,
    input  logic                             result_stall,
    output bmp_pkg::result_item_t            result_item,
    input  logic                             cfg_we,
    input  logic [bmp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bmp_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // Configuration registers, shared by the parser (origin check) and the
    // formatter (screen coordinates).
    bmp_pkg::cfg_regs_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.origin_x       <= 16'sd0;
            cfg_reg.origin_y       <= 16'sd0;
            cfg_reg.display_width  <= 16'd240;
            cfg_reg.display_height <= 16'd240;
        end
        else if (cfg_we)
        begin
            unique case (bmp_pkg::reg_index_t'(cfg_index))
                bmp_pkg::REG_ORIGIN_X:       cfg_reg.origin_x       <= $signed(cfg_data);
                bmp_pkg::REG_ORIGIN_Y:       cfg_reg.origin_y       <= $signed(cfg_data);
                bmp_pkg::REG_DISPLAY_WIDTH:  cfg_reg.display_width  <= cfg_data;
                bmp_pkg::REG_DISPLAY_HEIGHT: cfg_reg.display_height <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // The parser advances on every accepted byte; it only needs room in the
    // queue for the one result that a byte may produce.
    bmp_pkg::q_push_t   q_push;
    bmp_pkg::q_entry_t  q_head;
    bmp_pkg::q_status_t q_status;
    logic               q_pop;
    logic               file_accept;
    logic               parse_done;

    assign file_stall  = q_status.full;
    assign file_accept = file_valid && !q_status.full;

    bmp_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (file_accept),
        .item   (file_item),
        .cfg    (cfg_reg),
        .push   (q_push),
        .done   (parse_done)
    );

    bmp_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .pop    (q_pop),
        .head   (q_head),
        .status (q_status)
    );

    // The formatter packs RGB565 and adds the origin to the pixel position.
    bmp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (q_head),
        .q_empty      (q_status.empty),
        .cfg          (cfg_reg),
        .pop          (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

    // A status result carries no pixel and always ends the image.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_item.result_kind != bmp_pkg::KIND_PIXEL)
        |-> (result_item.last && result_item.pixel_rgb565 == 16'd0))
        else $error("status result without last or with pixel data");

    // The final result of an image leaves the parser in its done state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_push.valid && q_push.entry.last) |=> parse_done)
        else $error("parser not done after final result");

    // The formatter only takes from a queue that holds something.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("pop from empty queue");

    // A result pushed into an empty queue is held or being popped in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_push.valid && q_status.empty && (!result_valid || !result_stall))
        |=> (q_pop && !result_stall) || (!q_status.empty))
        else $error("queued result lost");

endmodule

/* hw/rtl/bmp_front.sv */
module bmp_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  bmp_pkg::file_item_t   item,
    input  bmp_pkg::cfg_regs_t    cfg,
    output bmp_pkg::q_push_t      push,
    output logic                  done
);

    bmp_pkg::phase_t phase_reg, phase_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] offset_reg, offset_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic [31:0] shift_reg, shift_next;
    logic [15:0] col_reg, col_next;
    logic [15:0] row_reg, row_next;
    logic [1:0]  triple_reg, triple_next;
    logic [7:0]  blue_reg, blue_next;
    logic [7:0]  green_reg, green_next;
    logic [1:0]  pad_reg, pad_next;

    bmp_pkg::q_push_t push_c;

    always_comb
    begin
        bmp_pkg::phase_t ph;
        logic        sof;
        logic [7:0]  b;
        logic [31:0] shift_new;
        logic [15:0] col_inc;
        logic        offscreen;
        logic        emit_pixel;

        sof = item.start_of_file;
        b   = item.file_byte;

        // A start-of-file byte restarts the parse before it is processed.
        ph          = sof ? bmp_pkg::PH_HEADER : phase_reg;
        phase_next  = ph;
        pos_next    = sof ? 32'd0 : pos_reg;
        offset_next = sof ? 32'd0 : offset_reg;
        width_next  = sof ? 16'd0 : width_reg;
        height_next = sof ? 16'd0 : height_reg;
        shift_next  = sof ? 32'd0 : shift_reg;
        col_next    = sof ? 16'd0 : col_reg;
        row_next    = sof ? 16'd0 : row_reg;
        triple_next = sof ? 2'd0 : triple_reg;
        blue_next   = sof ? 8'd0 : blue_reg;
        green_next  = sof ? 8'd0 : green_reg;
        pad_next    = sof ? 2'd0 : pad_reg;

        shift_new  = {b, shift_next[31:8]};
        col_inc    = col_next + 16'd1;
        offscreen  = ($signed({cfg.origin_x[15], cfg.origin_x}) >=
                      $signed({1'b0, cfg.display_width})) ||
                     ($signed({cfg.origin_y[15], cfg.origin_y}) >=
                      $signed({1'b0, cfg.display_height}));
        emit_pixel = 1'b0;

        push_c.valid        = 1'b0;
        push_c.entry.kind   = bmp_pkg::KIND_PIXEL;
        push_c.entry.red    = b;
        push_c.entry.green  = green_next;
        push_c.entry.blue   = blue_next;
        push_c.entry.column = col_next;
        push_c.entry.row    = row_next;
        push_c.entry.height = height_next;
        push_c.entry.last   = 1'b1;

        unique case (ph)
            bmp_pkg::PH_HEADER:
            begin
                if (pos_next == 32'd0 && offscreen)
                begin
                    push_c.valid      = 1'b1;
                    push_c.entry.kind = bmp_pkg::KIND_OFFSCREEN;
                    phase_next        = bmp_pkg::PH_DONE;
                end
                else
                begin
                    shift_next = shift_new;
                    pos_next   = pos_next + 32'd1;
                    unique case (pos_next - 32'd1)
                        bmp_pkg::POS_MAGIC_END:
                        begin
                            if (shift_new[31:16] != bmp_pkg::MAGIC_BM)
                            begin
                                push_c.valid      = 1'b1;
                                push_c.entry.kind = bmp_pkg::KIND_BAD_MAGIC;
                                phase_next        = bmp_pkg::PH_DONE;
                            end
                        end
                        bmp_pkg::POS_OFFSET_END: offset_next = shift_new;
                        bmp_pkg::POS_WIDTH_END:  width_next  = shift_new[15:0];
                        bmp_pkg::POS_HEIGHT_END: height_next = shift_new[15:0];
                        bmp_pkg::POS_PLANES_END:
                        begin
                            if (shift_new[31:16] != bmp_pkg::PLANES_ONE)
                            begin
                                push_c.valid      = 1'b1;
                                push_c.entry.kind = bmp_pkg::KIND_BAD_FORMAT;
                                phase_next        = bmp_pkg::PH_DONE;
                            end
                        end
                        bmp_pkg::POS_BPP_END:
                        begin
                            if (shift_new[31:16] != bmp_pkg::BITS_PER_PIXEL)
                            begin
                                push_c.valid      = 1'b1;
                                push_c.entry.kind = bmp_pkg::KIND_BAD_FORMAT;
                                phase_next        = bmp_pkg::PH_DONE;
                            end
                        end
                        bmp_pkg::POS_COMP_END:
                        begin
                            if (shift_new != 32'd0)
                            begin
                                push_c.valid      = 1'b1;
                                push_c.entry.kind = bmp_pkg::KIND_BAD_FORMAT;
                                phase_next        = bmp_pkg::PH_DONE;
                            end
                            else if (width_next == 16'd0 || height_next == 16'd0)
                            begin
                                push_c.valid      = 1'b1;
                                push_c.entry.kind = bmp_pkg::KIND_EMPTY;
                                phase_next        = bmp_pkg::PH_DONE;
                            end
                            else if (offset_next <= bmp_pkg::HEADER_LEN)
                            begin
                                phase_next = bmp_pkg::PH_PIXEL;
                            end
                            else
                            begin
                                phase_next = bmp_pkg::PH_SKIP;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            bmp_pkg::PH_SKIP:
            begin
                if (pos_next >= offset_next)
                begin
                    phase_next = bmp_pkg::PH_PIXEL;
                    emit_pixel = 1'b1;
                end
                else
                begin
                    pos_next = pos_next + 32'd1;
                end
            end
            bmp_pkg::PH_PIXEL:
            begin
                emit_pixel = 1'b1;
            end
            bmp_pkg::PH_PAD:
            begin
                pad_next = pad_next - 2'd1;
                if (pad_next == 2'd0)
                begin
                    phase_next = bmp_pkg::PH_PIXEL;
                end
            end
            bmp_pkg::PH_DONE:
            begin
            end
            default:
            begin
            end
        endcase

        // Blue, green, then red completes a pixel.
        if (emit_pixel)
        begin
            case (triple_next)
                2'd0:
                begin
                    blue_next   = b;
                    triple_next = 2'd1;
                end
                2'd1:
                begin
                    green_next  = b;
                    triple_next = 2'd2;
                end
                default:
                begin
                    triple_next       = 2'd0;
                    push_c.valid      = 1'b1;
                    push_c.entry.last = 1'b0;
                    col_next          = col_inc;
                    if (col_inc >= width_next)
                    begin
                        col_next = 16'd0;
                        if ({1'b0, row_next} + 17'd1 >= {1'b0, height_next})
                        begin
                            push_c.entry.last = 1'b1;
                            phase_next        = bmp_pkg::PH_DONE;
                        end
                        else
                        begin
                            row_next = row_next + 16'd1;
                            // Row padding equals width mod 4 for 3-byte pixels.
                            pad_next = width_next[1:0];
                            if (width_next[1:0] != 2'd0)
                            begin
                                phase_next = bmp_pkg::PH_PAD;
                            end
                        end
                    end
                end
            endcase
        end

        if (!accept)
        begin
            push_c.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= bmp_pkg::PH_HEADER;
            pos_reg    <= '0;
            offset_reg <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            shift_reg  <= '0;
            col_reg    <= '0;
            row_reg    <= '0;
            triple_reg <= '0;
            blue_reg   <= '0;
            green_reg  <= '0;
            pad_reg    <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            offset_reg <= offset_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            shift_reg  <= shift_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            triple_reg <= triple_next;
            blue_reg   <= blue_next;
            green_reg  <= green_next;
            pad_reg    <= pad_next;
        end
    end

    assign push = push_c;
    assign done = (phase_reg == bmp_pkg::PH_DONE);

endmodule

/* hw/rtl/bmp_fifo.sv */
module bmp_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  bmp_pkg::q_push_t    push,
    input  logic                pop,
    output bmp_pkg::q_entry_t   head,
    output bmp_pkg::q_status_t  status
);

    bmp_pkg::q_entry_t slot_reg [bmp_pkg::QDEPTH];

    logic [bmp_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [bmp_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [bmp_pkg::QCNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push.valid ? wr_ptr_reg + bmp_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + bmp_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push.valid && !pop)
        begin
            count_next = count_reg + bmp_pkg::QCNT_W'(1);
        end
        else if (!push.valid && pop)
        begin
            count_next = count_reg - bmp_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            slot_reg[wr_ptr_reg] <= push.entry;
        end
    end

    assign head         = slot_reg[rd_ptr_reg];
    assign status.full  = (count_reg == bmp_pkg::QCNT_W'(bmp_pkg::QDEPTH));
    assign status.empty = (count_reg == '0);

endmodule

/* hw/rtl/bmp_back.sv */
module bmp_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  bmp_pkg::q_entry_t      head,
    input  logic                   q_empty,
    input  bmp_pkg::cfg_regs_t     cfg,
    output logic                   pop,
    output logic                   result_valid,
    input  logic                   result_stall,
    output bmp_pkg::result_item_t  result_item
);

    logic                  valid_reg;
    bmp_pkg::result_item_t item_reg, item_next;

    always_comb
    begin
        logic [7:0] red_m;
        logic [7:0] green_m;

        red_m   = head.red & bmp_pkg::RED_MASK;
        green_m = head.green & bmp_pkg::GREEN_MASK;

        item_next.result_kind = head.kind;
        item_next.last        = head.last;
        if (head.kind == bmp_pkg::KIND_PIXEL)
        begin
            item_next.pixel_rgb565 = {red_m[7:3], green_m[7:2], head.blue[7:3]};
            item_next.screen_x     = cfg.origin_x + $signed(head.column);
            item_next.screen_y     = cfg.origin_y + $signed(head.height) - 16'sd1
                                     - $signed(head.row);
        end
        else
        begin
            item_next.pixel_rgb565 = '0;
            item_next.screen_x     = '0;
            item_next.screen_y     = '0;
        end
    end

    assign pop = !q_empty && (!valid_reg || !result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= item_next;
        end
    end

    assign result_valid = valid_reg;
    assign result_item  = item_reg;

endmodule

/* tb/bmp_decode_checker.sv */
`timescale 1ns / 100ps

// Watches the file, result and register channels of the BMP decoder. Every accepted
// file byte is run through an independent decoder model, and every accepted result is
// compared with the oldest decoded result still waiting.
module bmp_decode_checker
    import bmp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         file_valid,
    input  logic         file_stall,
    input  file_item_t   file_item,
    input  logic         result_valid,
    input  logic         result_stall,
    input  result_item_t result_item,
    input  logic         cfg_we,
    input  reg_index_t   cfg_index,
    input  logic [15:0]  cfg_data,
    output int           fail_count,
    output int           pending,
    output int           parsed_items
);

    // Byte positions at which a header field is complete.
    localparam logic [31:0] MAGIC_DONE  = 32'd1;
    localparam logic [31:0] OFFSET_DONE = 32'd13;
    localparam logic [31:0] WIDTH_DONE  = 32'd21;
    localparam logic [31:0] HEIGHT_DONE = 32'd25;
    localparam logic [31:0] PLANES_DONE = 32'd27;
    localparam logic [31:0] BPP_DONE    = 32'd29;
    localparam logic [31:0] COMP_DONE   = 32'd33;
    localparam logic [31:0] HDR_BYTES   = 32'd34;
    localparam logic [15:0] BM_MAGIC    = 16'h4D42;

    typedef enum logic [2:0] {
        ST_HEADER,
        ST_SKIP,
        ST_PIXEL,
        ST_PAD,
        ST_DONE
    } parse_state_t;

    logic signed [15:0] org_x;
    logic signed [15:0] org_y;
    logic [15:0]        disp_w;
    logic [15:0]        disp_h;

    parse_state_t state;
    logic [31:0]  byte_pos;
    logic [31:0]  pix_offset;
    logic [31:0]  hdr_shift;
    logic [15:0]  img_w;
    logic [15:0]  img_h;
    logic [15:0]  col;
    logic [15:0]  row;
    logic [1:0]   tri_idx;
    logic [1:0]   pad_left;
    logic [7:0]   blue_b;
    logic [7:0]   green_b;

    result_item_t decoded_q[$];
    int           errors;
    int           parsed;

    task automatic restart_parse();
        state      = ST_HEADER;
        byte_pos   = '0;
        pix_offset = '0;
        hdr_shift  = '0;
        img_w      = '0;
        img_h      = '0;
        col        = '0;
        row        = '0;
        tri_idx    = '0;
        pad_left   = '0;
        blue_b     = '0;
        green_b    = '0;
    endtask

    task automatic push_status(input kind_t kind);
        result_item_t r;
        r             = '0;
        r.result_kind = kind;
        r.last        = 1'b1;
        decoded_q.push_back(r);
        state = ST_DONE;
    endtask

    task automatic take_pixel_byte(input logic [7:0] fb);
        result_item_t r;
        logic [31:0]  row_bytes;
        if (tri_idx == 2'd0)
        begin
            blue_b  = fb;
            tri_idx = 2'd1;
        end
        else if (tri_idx == 2'd1)
        begin
            green_b = fb;
            tri_idx = 2'd2;
        end
        else
        begin
            tri_idx        = 2'd0;
            r.result_kind  = KIND_PIXEL;
            r.pixel_rgb565 = {fb[7:3], green_b[7:2], blue_b[7:3]};
            r.screen_x     = org_x + col;
            r.screen_y     = org_y + img_h - 16'd1 - row;
            r.last         = 1'b0;
            col            = col + 16'd1;
            if (col >= img_w)
            begin
                col = '0;
                if ({16'd0, row} + 32'd1 >= {16'd0, img_h})
                begin
                    r.last = 1'b1;
                    state  = ST_DONE;
                end
                else
                begin
                    row       = row + 16'd1;
                    row_bytes = {16'd0, img_w} * 32'd3;
                    // Rows are padded up to a multiple of four bytes.
                    pad_left  = 2'd0 - row_bytes[1:0];
                    if (pad_left != 2'd0)
                        state = ST_PAD;
                end
            end
            decoded_q.push_back(r);
        end
    endtask

    task automatic take_header_byte(input logic [7:0] fb);
        logic [31:0] p;
        p         = byte_pos;
        hdr_shift = {fb, hdr_shift[31:8]};
        byte_pos  = p + 32'd1;
        case (p)
            MAGIC_DONE:
                if (hdr_shift[31:16] != BM_MAGIC)
                    push_status(KIND_BAD_MAGIC);
            OFFSET_DONE: pix_offset = hdr_shift;
            WIDTH_DONE:  img_w = hdr_shift[15:0];
            HEIGHT_DONE: img_h = hdr_shift[15:0];
            PLANES_DONE:
                if (hdr_shift[31:16] != 16'd1)
                    push_status(KIND_BAD_FORMAT);
            BPP_DONE:
                if (hdr_shift[31:16] != 16'd24)
                    push_status(KIND_BAD_FORMAT);
            COMP_DONE:
                if (hdr_shift != 32'd0)
                    push_status(KIND_BAD_FORMAT);
                else if (img_w == 16'd0 || img_h == 16'd0)
                    push_status(KIND_EMPTY);
                else
                    state = (pix_offset <= HDR_BYTES) ? ST_PIXEL : ST_SKIP;
            default: ;
        endcase
    endtask

    task automatic decode_byte(input file_item_t it);
        if (it.start_of_file)
            restart_parse();
        if (state != ST_DONE)
            parsed++;
        case (state)
            ST_HEADER:
                if (byte_pos == 32'd0 &&
                    (int'(org_x) >= int'(disp_w) || int'(org_y) >= int'(disp_h)))
                    push_status(KIND_OFFSCREEN);
                else
                    take_header_byte(it.file_byte);
            ST_SKIP:
                if (byte_pos >= pix_offset)
                begin
                    state = ST_PIXEL;
                    take_pixel_byte(it.file_byte);
                end
                else
                    byte_pos = byte_pos + 32'd1;
            ST_PIXEL:
                take_pixel_byte(it.file_byte);
            ST_PAD:
            begin
                pad_left = pad_left - 2'd1;
                if (pad_left == 2'd0)
                    state = ST_PIXEL;
            end
            default: ;
        endcase
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%04h, got 0x%04h", name, want, got);
            errors++;
        end
    endtask

    task automatic check_result(input result_item_t got);
        result_item_t want;
        if (decoded_q.size() == 0)
        begin
            $error("unexpected result: kind %0d, pixel 0x%04h, x %0d, y %0d",
                   got.result_kind, got.pixel_rgb565, got.screen_x, got.screen_y);
            errors++;
        end
        else
        begin
            want = decoded_q.pop_front();
            check_field("result_kind", 16'(want.result_kind), 16'(got.result_kind));
            check_field("pixel_rgb565", want.pixel_rgb565, got.pixel_rgb565);
            check_field("screen_x", want.screen_x, got.screen_x);
            check_field("screen_y", want.screen_y, got.screen_y);
            check_field("last", 16'(want.last), 16'(got.last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_x  = '0;
            org_y  = '0;
            disp_w = 16'd240;
            disp_h = 16'd240;
            restart_parse();
            decoded_q.delete();
            errors       = 0;
            parsed       = 0;
            fail_count   <= 0;
            pending      <= 0;
            parsed_items <= 0;
        end
        else
        begin
            if (result_valid && !result_stall)
                check_result(result_item);
            if (file_valid && !file_stall)
                decode_byte(file_item);
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ORIGIN_X:       org_x  = cfg_data;
                    REG_ORIGIN_Y:       org_y  = cfg_data;
                    REG_DISPLAY_WIDTH:  disp_w = cfg_data;
                    REG_DISPLAY_HEIGHT: disp_h = cfg_data;
                    default: ;
                endcase
            end
            fail_count   <= errors;
            pending      <= decoded_q.size();
            parsed_items <= parsed;
        end
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

// Top of the BMP decoder testbench. It builds BMP files byte by byte, streams them into
// the decoder with random gaps, stalls the result side at random, and writes the
// display registers between files and once inside an image. All checking lives in the
// checker instance; this module only makes stimulus and decides the verdict at the end.
module tb_top;
    import bmp_pkg::*;

    // The cycle limit stops a run that hangs; it leaves room for the long hold-off on the
    // result side and the idle cycles on both sides.
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 250;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_PCT     = 28;

    logic         clk;
    logic         rst_n;
    logic         file_valid;
    logic         file_stall;
    file_item_t   file_item;
    logic         result_valid;
    logic         result_stall;
    result_item_t result_item;
    logic         cfg_we;
    reg_index_t   cfg_index;
    logic [15:0]  cfg_data;

    int fail_count;
    int pending;
    int parsed_items;
    int cycle_count;

    // The file being sent, one entry per byte.
    logic [7:0] fbuf[$];

    // quiet switches off idling on both sides; press_req asks the result side for one
    // long hold-off.
    bit quiet;
    bit press_req;

    bmp24_stream_to_rgb565 u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .file_valid   (file_valid),
        .file_stall   (file_stall),
        .file_item    (file_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    bmp_decode_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .file_valid   (file_valid),
        .file_stall   (file_stall),
        .file_item    (file_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .parsed_items (parsed_items)
    );

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        file_valid   = 1'b0;
        file_item    = '0;
        result_stall = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_ORIGIN_X;
        cfg_data     = '0;
        quiet        = 1'b0;
        press_req    = 1'b0;
    end

    always #10 clk = ~clk;

    // The run is cut off if the stimulus or the results get stuck.
    initial
        cycle_count = 0;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side. It stalls at random, except in the quiet stretch, and once holds off
    // for a long time so that the decoder's queue fills and the file side stalls too.
    initial
    begin
        int hold_left;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (press_req)
            begin
                press_req = 1'b0;
                hold_left = HOLD_CYCLES;
                result_stall <= 1'b1;
            end
            else
                result_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Pixel bytes lean toward the extremes so that every color bit is seen both ways.
    function automatic logic [7:0] pick_pixel();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] extreme16();
        case ($urandom_range(4))
            0:       return 16'h0000;
            1:       return 16'h0001;
            2:       return 16'h7FFF;
            3:       return 16'h8000;
            default: return 16'hFFFF;
        endcase
    endfunction

    // Offers one item and returns at the edge that accepts it. The valid stays high on
    // return, so the next item follows without a gap unless an idle is drawn.
    task automatic send_item(input logic [7:0] fb, input logic sof);
        if (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            file_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < IDLE_PCT);
        end
        file_valid <= 1'b1;
        file_item  <= '{file_byte: fb, start_of_file: sof};
        do
            @(posedge clk);
        while (file_stall);
    endtask

    task automatic send_span(input int from, input int upto, input logic sof_first);
        for (int i = from; i < upto; i++)
            send_item(fbuf[i], sof_first && i == from);
    endtask

    // Bytes with no start flag; after a finished image the decoder ignores them.
    task automatic add_junk(input int count);
        repeat (count)
            send_item(8'($urandom), 1'b0);
    endtask

    task automatic put_le(input logic [31:0] v, input int nbytes);
        for (int i = 0; i < nbytes; i++)
            fbuf.push_back(v[8*i +: 8]);
    endtask

    // Builds a complete file in fbuf: the 34 header bytes the decoder looks at, filler
    // up to the pixel offset, then the rows with their padding.
    task automatic make_bmp(input logic [15:0] magic, input logic [31:0] offset,
                            input logic [31:0] wf, input logic [31:0] hf,
                            input logic [15:0] planes, input logic [15:0] bpp,
                            input logic [31:0] comp);
        int row_bytes;
        int pad;
        fbuf.delete();
        put_le({16'd0, magic}, 2);
        put_le($urandom, 4);
        put_le($urandom, 4);
        put_le(offset, 4);
        put_le(32'd40, 4);
        put_le(wf, 4);
        put_le(hf, 4);
        put_le({16'd0, planes}, 2);
        put_le({16'd0, bpp}, 2);
        put_le(comp, 4);
        while (fbuf.size() < offset)
            fbuf.push_back(8'($urandom));
        row_bytes = 3 * wf[15:0];
        pad       = (4 - row_bytes % 4) % 4;
        for (int r = 0; r < hf[15:0]; r++)
        begin
            for (int i = 0; i < row_bytes; i++)
                fbuf.push_back(pick_pixel());
            for (int i = 0; i < pad; i++)
                fbuf.push_back(8'($urandom));
        end
    endtask

    task automatic send_good(input int w, input int h, input int offset);
        make_bmp(MAGIC_BM, offset, w, h, 16'd1, 16'd24, 32'd0);
        send_span(0, fbuf.size(), 1'b1);
    endtask

    // Drops the file valid, waits until every decoded result has come out, and then waits
    // out bytes that are still on their way through the decoder.
    task automatic wait_idle();
        file_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    // Writes all four display registers on consecutive edges while the decoder is idle.
    task automatic set_config(input logic [15:0] ox, input logic [15:0] oy,
                              input logic [15:0] dw, input logic [15:0] dh);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_ORIGIN_X;
        cfg_data  <= ox;
        @(posedge clk);
        cfg_index <= REG_ORIGIN_Y;
        cfg_data  <= oy;
        @(posedge clk);
        cfg_index <= REG_DISPLAY_WIDTH;
        cfg_data  <= dw;
        @(posedge clk);
        cfg_index <= REG_DISPLAY_HEIGHT;
        cfg_data  <= dh;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Mostly on-screen origins on a plausible display, with some extreme values and
    // some fully random ones, which can put the origin off screen.
    task automatic random_config();
        int k;
        k = $urandom_range(9);
        if (k < 6)
            set_config(16'($urandom_range(300)) - 16'd60, 16'($urandom_range(300)) - 16'd60,
                       16'($urandom_range(120, 400)), 16'($urandom_range(120, 400)));
        else if (k < 8)
            set_config(extreme16(), extreme16(), extreme16(), extreme16());
        else
            set_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // One random file. Most are well formed with random sizes, offsets and contents, so
    // that the pixel and padding logic gets most of the traffic. The rest carry a bad
    // header field, an empty size, a cut-off end, or are plain noise.
    task automatic random_file();
        int          sel;
        int          w;
        int          h;
        int          k;
        int          offset;
        int          cut;
        logic [15:0] magic;
        logic [15:0] planes;
        logic [15:0] bpp;
        logic [31:0] comp;
        logic [31:0] wf;
        logic [31:0] hf;
        sel = $urandom_range(99);
        if (sel >= 90)
        begin
            repeat ($urandom_range(5, 40))
                send_item(8'($urandom), $urandom_range(15) == 0);
        end
        else
        begin
            w = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
            h = $urandom_range(1, 4);
            k = $urandom_range(9);
            if (k < 3)
                offset = $urandom_range(34);
            else if (k < 7)
                offset = 54;
            else
                offset = $urandom_range(35, 90);
            magic  = MAGIC_BM;
            planes = 16'd1;
            bpp    = 16'd24;
            comp   = 32'd0;
            wf     = w;
            hf     = h;
            // The upper halves of width and height are ignored by the decoder.
            if ($urandom_range(3) == 0)
            begin
                wf[31:16] = 16'($urandom);
                hf[31:16] = 16'($urandom);
            end
            if (sel >= 66 && sel < 70)
                magic = MAGIC_BM ^ (16'd1 << $urandom_range(15));
            else if (sel >= 70 && sel < 74)
                planes = ($urandom_range(1) == 0) ? 16'd0 : 16'($urandom) | 16'd2;
            else if (sel >= 74 && sel < 78)
                bpp = 16'd24 ^ (16'd1 << $urandom_range(15));
            else if (sel >= 78 && sel < 82)
                comp = 32'd1 << $urandom_range(31);
            else if (sel >= 82 && sel < 86)
                wf[15:0] = 16'd0;
            else if (sel >= 86)
                hf[15:0] = 16'd0;
            make_bmp(magic, offset, wf, hf, planes, bpp, comp);
            cut = fbuf.size();
            // A cut-off file is followed by a new start flag in the next file.
            if ($urandom_range(9) == 0)
                cut = $urandom_range(1, fbuf.size() - 1);
            send_span(0, cut, 1'b1);
            if ($urandom_range(4) == 0)
                add_junk($urandom_range(1, 5));
        end
    endtask

    initial
    begin
        int rnd_base;
        int file_no;

        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed files. The first byte after reset starts a file without the flag.
        make_bmp(MAGIC_BM, 32'd54, 32'd3, 32'd2, 16'd1, 16'd24, 32'd0);
        send_span(0, fbuf.size(), 1'b0);

        // Offset pointing into the header, one pad byte per row, upper size bits set.
        // The junk after the last pixel must be ignored.
        make_bmp(MAGIC_BM, 32'd0, 32'hABCD_0001, 32'h8000_0002, 16'd1, 16'd24, 32'd0);
        send_span(0, fbuf.size(), 1'b1);
        add_junk(3);
        send_good(2, 3, 34);
        send_good(4, 1, 40);

        // Bad magic in the first byte, then in the second.
        make_bmp(16'h4D43, 32'd54, 32'd2, 32'd2, 16'd1, 16'd24, 32'd0);
        send_span(0, 8, 1'b1);
        make_bmp(16'hCD42, 32'd54, 32'd2, 32'd2, 16'd1, 16'd24, 32'd0);
        send_span(0, 8, 1'b1);

        // Unsupported plane count, depth and compression.
        make_bmp(MAGIC_BM, 32'd54, 32'd2, 32'd2, 16'd0, 16'd24, 32'd0);
        send_span(0, 34, 1'b1);
        make_bmp(MAGIC_BM, 32'd54, 32'd2, 32'd2, 16'd1, 16'd32, 32'd0);
        send_span(0, 34, 1'b1);
        make_bmp(MAGIC_BM, 32'd54, 32'd2, 32'd2, 16'd1, 16'd24, 32'h8000_0000);
        send_span(0, 34, 1'b1);

        // Empty images: width zero in its low half, then height zero.
        make_bmp(MAGIC_BM, 32'd54, 32'h0001_0000, 32'd2, 16'd1, 16'd24, 32'd0);
        send_span(0, fbuf.size(), 1'b1);
        make_bmp(MAGIC_BM, 32'd54, 32'd2, 32'd0, 16'd1, 16'd24, 32'd0);
        send_span(0, fbuf.size(), 1'b1);

        // Restarts while skipping to the data, inside row padding, in the middle of a
        // pixel and inside the header.
        make_bmp(MAGIC_BM, 32'd80, 32'd2, 32'd2, 16'd1, 16'd24, 32'd0);
        send_span(0, 50, 1'b1);
        make_bmp(MAGIC_BM, 32'd34, 32'd2, 32'd2, 16'd1, 16'd24, 32'd0);
        send_span(0, 41, 1'b1);
        make_bmp(MAGIC_BM, 32'd54, 32'd5, 32'd3, 16'd1, 16'd24, 32'd0);
        send_span(0, 61, 1'b1);
        send_span(0, 20, 1'b1);
        send_span(0, fbuf.size(), 1'b1);

        // The origin moves in the middle of an image, inside the padding after the first row.
        // Later pixels take the new origin.
        make_bmp(MAGIC_BM, 32'd34, 32'd3, 32'd3, 16'd1, 16'd24, 32'd0);
        send_span(0, 44, 1'b1);
        set_config(16'hFFFB, 16'd7, 16'd240, 16'd240);
        send_span(44, fbuf.size(), 1'b0);

        // Origin off screen on either axis, and a zero sized display.
        set_config(16'd240, 16'd0, 16'd240, 16'd240);
        send_good(2, 2, 54);
        set_config(16'd0, 16'd240, 16'd240, 16'd240);
        send_good(2, 2, 54);
        set_config(16'd0, 16'd0, 16'd0, 16'd0);
        send_good(2, 2, 54);

        // Negative origins stay on screen even on a zero sized display.
        set_config(16'hFFFF, 16'h8000, 16'd0, 16'd0);
        send_good(2, 2, 54);

        // Coordinates wrap around at the top of the 16-bit range.
        set_config(16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF);
        send_good(3, 3, 34);
        set_config(16'd0, 16'd0, 16'd240, 16'd240);

        // Random files. The long hold-off on the result side comes first, while pixels
        // are flowing. The second and third files run without any idling.
        rnd_base  = parsed_items;
        file_no   = 0;
        press_req = 1'b1;
        while (parsed_items - rnd_base < RANDOM_ITEMS)
        begin
            quiet = (file_no >= 1 && file_no < 3);
            if (file_no % 3 == 2)
                random_config();
            random_file();
            file_no++;
        end
        quiet = 1'b0;

        // Let the last results drain, then give the decoder time to show anything extra.
        wait_idle();
        repeat (16)
            @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/bmp_pkg.sv
hw/rtl/bmp_front.sv
hw/rtl/bmp_fifo.sv
hw/rtl/bmp_back.sv
hw/rtl/bmp24_stream_to_rgb565.sv
tb/bmp_decode_checker.sv
tb/tb_top.sv
